FILE: rtl/core/spectral_maxwell_point_update_unit_macros.svh
// Assertion macros shared by the point update unit
`ifndef SPECTRAL_MAXWELL_POINT_UPDATE_UNIT_MACROS_SVH
`define SPECTRAL_MAXWELL_POINT_UPDATE_UNIT_MACROS_SVH
`ifndef SYNTH
`define SMPU_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`define SMPU_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define SMPU_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define SMPU_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

FILE: rtl/core/smpu_pkg.sv
// Types, codes and helpers of the point update unit
package smpu_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_UPD_E = 2'd2,
        OP_UPD_B = 2'd3
    } op_t;

    localparam logic [2:0] COMP_EX = 3'd0;
    localparam logic [2:0] COMP_EY = 3'd1;
    localparam logic [2:0] COMP_EZ = 3'd2;
    localparam logic [2:0] COMP_BX = 3'd3;
    localparam logic [2:0] COMP_BY = 3'd4;
    localparam logic [2:0] COMP_BZ = 3'd5;

    localparam logic [1:0] CFG_STEP_X = 2'd0;
    localparam logic [1:0] CFG_STEP_Y = 2'd1;
    localparam logic [1:0] CFG_STEP_Z = 2'd2;
    localparam logic [1:0] CFG_WRAP   = 2'd3;

    localparam int IDX_BITS  = 10;
    localparam int K_BITS    = 44;
    localparam int FRAC_BITS = 24;

    function automatic logic signed [K_BITS-1:0] wavenum(
        input logic [IDX_BITS-1:0] i,
        input logic [IDX_BITS:0]   n,
        input logic                wrap,
        input logic [31:0]         step
    );
        logic signed [11:0] s;
        logic signed [45:0] prod;
        s = $signed({2'b00, i});
        if (wrap && ({1'b0, i, 1'b0} > {1'b0, n}))
        begin
            s = s - $signed({1'b0, n});
        end
        prod = 46'(s) * $signed({14'd0, step});
        return prod[K_BITS-1:0];
    endfunction

endpackage

FILE: rtl/core/smpu_in_if.sv
// Input channel of the point update unit
interface smpu_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [6:0]         ix;
    logic [4:0]         iy;
    logic [4:0]         iz;
    logic [2:0]         component;
    logic signed [31:0] value_re;
    logic signed [31:0] value_im;

    modport source (output valid, operation, ix, iy, iz, component, value_re, value_im,
                    input ready);
    modport sink (input valid, operation, ix, iy, iz, component, value_re, value_im,
                  output ready);
endinterface

FILE: rtl/core/smpu_out_if.sv
// Result channel of the point update unit
interface smpu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] data_re;
    logic signed [31:0] data_im;
    logic               saturated;

    modport source (output valid, data_re, data_im, saturated, input ready);
    modport sink (input valid, data_re, data_im, saturated, output ready);
endinterface

FILE: rtl/core/smpu_field_mem.sv
// One complex field store: synchronous memory, one write and one registered read port
module smpu_field_mem #(
    parameter int DEPTH = 131072,
    parameter int AW    = 17,
    parameter int DW    = 64
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

FILE: rtl/core/smpu_cross_unit.sv
// Cross term unit: round((ka*p - kb*q) / 2^24) for both parts over two stages
module smpu_cross_unit #(
    parameter int FB = 32,
    parameter int TW = FB + 22
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [smpu_pkg::K_BITS-1:0] ka,
    input  logic signed [smpu_pkg::K_BITS-1:0] kb,
    input  logic signed [FB-1:0]              p_re,
    input  logic signed [FB-1:0]              p_im,
    input  logic signed [FB-1:0]              q_re,
    input  logic signed [FB-1:0]              q_im,
    output logic signed [TW-1:0]              t_re,
    output logic signed [TW-1:0]              t_im
);
    import smpu_pkg::*;

    localparam int HIB = K_BITS - FRAC_BITS;
    localparam int HW  = HIB + FB;
    localparam int LW  = FRAC_BITS + 1 + FB;

    logic signed [HIB-1:0]      ka_hi, kb_hi;
    logic signed [FRAC_BITS:0]  ka_lo, kb_lo;
    logic signed [HW-1:0]       hpa_re_reg, hpa_im_reg, hpb_re_reg, hpb_im_reg;
    logic signed [LW-1:0]       lpa_re_reg, lpa_im_reg, lpb_re_reg, lpb_im_reg;
    logic signed [HW:0]         hd_re, hd_im;
    logic signed [LW+1:0]       ld_re, ld_im;
    logic signed [LW+1:0]       lr_re, lr_im;
    logic signed [TW-1:0]       t_re_next, t_im_next;
    logic signed [TW-1:0]       t_re_reg, t_im_reg;

    assign ka_hi = ka[K_BITS-1:FRAC_BITS];
    assign kb_hi = kb[K_BITS-1:FRAC_BITS];
    assign ka_lo = $signed({1'b0, ka[FRAC_BITS-1:0]});
    assign kb_lo = $signed({1'b0, kb[FRAC_BITS-1:0]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hpa_re_reg <= HW'(ka_hi * p_re);
            hpa_im_reg <= HW'(ka_hi * p_im);
            hpb_re_reg <= HW'(kb_hi * q_re);
            hpb_im_reg <= HW'(kb_hi * q_im);
            lpa_re_reg <= LW'(ka_lo * p_re);
            lpa_im_reg <= LW'(ka_lo * p_im);
            lpb_re_reg <= LW'(kb_lo * q_re);
            lpb_im_reg <= LW'(kb_lo * q_im);
            t_re_reg   <= t_re_next;
            t_im_reg   <= t_im_next;
        end
    end

    always_comb
    begin
        hd_re = (HW+1)'(hpa_re_reg) - (HW+1)'(hpb_re_reg);
        hd_im = (HW+1)'(hpa_im_reg) - (HW+1)'(hpb_im_reg);
        ld_re = (LW+2)'(lpa_re_reg) - (LW+2)'(lpb_re_reg) + $signed((LW+2)'(1) << 23);
        ld_im = (LW+2)'(lpa_im_reg) - (LW+2)'(lpb_im_reg) + $signed((LW+2)'(1) << 23);
        lr_re = ld_re >>> FRAC_BITS;
        lr_im = ld_im >>> FRAC_BITS;
        t_re_next = TW'(hd_re) + lr_re[TW-1:0];
        t_im_next = TW'(hd_im) + lr_im[TW-1:0];
    end

    assign t_re = t_re_reg;
    assign t_im = t_im_reg;
endmodule

FILE: rtl/core/spectral_maxwell_point_update_unit.sv
// Top level of the pseudo-spectral Maxwell point update unit
// Input channel in_ch takes one item per transfer: write a component, read it back,
// update E at a point or update B at a point. Result channel out_ch returns exactly
// one result per item: read data for reads, zeros otherwise, and a flag when an
// update clipped a component. Steps and frequency wrap are set through the write
// port (cfg_we, cfg_index, cfg_data); the user must write them only while the
// unit is idle, since the block itself does not enforce this.
// An item passes the memory read register, loaded at the transfer edge, then the
// product stage, cross term stage and output register, at one item per cycle
// unless stalled. An item stalls while an earlier write or update to the same
// grid point is still in flight, until its write-back to the field memories.
// The six field stores are synchronous memories; their contents are undefined
// until written and reset does not touch them. Reset clears the pipeline and sets
// the registers to zero steps with frequency wrap on.
// When the receiver stalls, the whole pipeline holds and ready falls, so no
// result is lost or repeated.
module spectral_maxwell_point_update_unit #(
    parameter int X_POINTS   = 128,
    parameter int Y_POINTS   = 32,
    parameter int Z_POINTS   = 32,
    parameter int FIELD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    smpu_in_if.sink     in_ch,
    smpu_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import smpu_pkg::*;
    `include "spectral_maxwell_point_update_unit_macros.svh"

    localparam int FB    = FIELD_BITS;
    localparam int DW    = 2 * FB;
    localparam int DEPTH = X_POINTS * Y_POINTS * Z_POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = FB + 22;
    localparam int UW    = TW + 1;

    typedef struct packed {
        op_t           op;
        logic          ok;
        logic [2:0]    comp;
        logic [AW-1:0] addr;
        logic [DW-1:0] wval;
    } ctl_t;

    logic [31:0] step_x_reg, step_y_reg, step_z_reg;
    logic        wrap_reg;

    logic        en, hazard, in_xfer;
    logic [31:0] addr_full;
    logic [AW-1:0] in_addr;
    logic        in_ok;
    ctl_t        in_ctl;

    logic  p1_valid_reg, p2_valid_reg, p3_valid_reg;
    ctl_t  p1_ctl_reg, p2_ctl_reg, p3_ctl_reg;
    logic signed [K_BITS-1:0] kx_reg, ky_reg, kz_reg;

    logic [DW-1:0] rd_data [6];
    logic [5:0]    we;
    logic [DW-1:0] wdata [6];

    logic [DW-1:0] src [3];
    logic [DW-1:0] old [3];
    logic [DW-1:0] p1_rdata;
    logic [DW-1:0] p2_rdata_reg, p3_rdata_reg;
    logic [DW-1:0] p2_old_reg [3];
    logic [DW-1:0] p3_old_reg [3];

    logic signed [TW-1:0] t_re [3];
    logic signed [TW-1:0] t_im [3];
    logic [DW-1:0] upd [3];
    logic [2:0]    clip_hit;

    logic               out_valid_reg, sat_reg;
    logic signed [31:0] data_re_reg, data_im_reg;
    logic               p3_upd;

    function automatic logic [FB-1:0] clip_in(input logic [31:0] v);
        logic [FB-1:0] r;
        r = v[FB-1:0];
        if (!((&v[31:FB-1]) || !(|v[31:FB-1])))
        begin
            r = v[31] ? {1'b1, {(FB-1){1'b0}}} : {1'b0, {(FB-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic [FB:0] clip_upd(input logic signed [UW-1:0] v);
        logic [FB:0] r;
        r = {1'b0, v[FB-1:0]};
        if (!((&v[UW-1:FB-1]) || !(|v[UW-1:FB-1])))
        begin
            r = v[UW-1] ? {2'b11, {(FB-1){1'b0}}} : {2'b10, {(FB-1){1'b1}}};
        end
        return r;
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_x_reg <= '0;
            step_y_reg <= '0;
            step_z_reg <= '0;
            wrap_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STEP_X: step_x_reg <= cfg_data;
                CFG_STEP_Y: step_y_reg <= cfg_data;
                CFG_STEP_Z: step_z_reg <= cfg_data;
                CFG_WRAP:   wrap_reg   <= cfg_data[0];
                default:    wrap_reg   <= wrap_reg;
            endcase
        end
    end

    // accept
    assign addr_full = 32'(in_ch.ix) + 32'(in_ch.iy) * 32'(X_POINTS)
                     + 32'(in_ch.iz) * 32'(X_POINTS * Y_POINTS);
    assign in_addr = addr_full[AW-1:0];
    assign in_ok = (32'(in_ch.ix) < 32'(X_POINTS)) && (32'(in_ch.iy) < 32'(Y_POINTS))
                && (32'(in_ch.iz) < 32'(Z_POINTS));

    always_comb
    begin
        in_ctl.op   = op_t'(in_ch.operation);
        in_ctl.ok   = in_ok;
        in_ctl.comp = in_ch.component;
        in_ctl.addr = in_addr;
        in_ctl.wval = {clip_in(in_ch.value_re), clip_in(in_ch.value_im)};
    end

    assign en = !out_valid_reg || out_ch.ready;
    assign hazard =
        (p1_valid_reg && p1_ctl_reg.ok && p1_ctl_reg.op != OP_READ && p1_ctl_reg.addr == in_addr)
     || (p2_valid_reg && p2_ctl_reg.ok && p2_ctl_reg.op != OP_READ && p2_ctl_reg.addr == in_addr)
     || (p3_valid_reg && p3_ctl_reg.ok && p3_ctl_reg.op != OP_READ && p3_ctl_reg.addr == in_addr);
    assign in_ch.ready = en && !hazard;
    assign in_xfer = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg  <= in_xfer;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            out_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_ctl_reg   <= in_ctl;
            kx_reg <= wavenum(IDX_BITS'(in_ch.ix), (IDX_BITS+1)'(X_POINTS), wrap_reg, step_x_reg);
            ky_reg <= wavenum(IDX_BITS'(in_ch.iy), (IDX_BITS+1)'(Y_POINTS), wrap_reg, step_y_reg);
            kz_reg <= wavenum(IDX_BITS'(in_ch.iz), (IDX_BITS+1)'(Z_POINTS), wrap_reg, step_z_reg);
            p2_ctl_reg   <= p1_ctl_reg;
            p3_ctl_reg   <= p2_ctl_reg;
            p2_rdata_reg <= p1_rdata;
            p3_rdata_reg <= p2_rdata_reg;
            p2_old_reg   <= old;
            p3_old_reg   <= p2_old_reg;
        end
    end

    // field stores
    for (genvar m = 0; m < 6; m++)
    begin : g_mem
        smpu_field_mem #(
            .DEPTH (DEPTH),
            .AW    (AW),
            .DW    (DW)
        ) u_mem (
            .clk     (clk),
            .rd_en   (en),
            .rd_addr (in_addr),
            .rd_data (rd_data[m]),
            .wr_en   (we[m]),
            .wr_addr (p3_ctl_reg.addr),
            .wr_data (wdata[m])
        );
    end

    // operand selection
    always_comb
    begin
        for (int d = 0; d < 3; d++)
        begin
            src[d] = (p1_ctl_reg.op == OP_UPD_B) ? rd_data[d] : rd_data[d+3];
            old[d] = (p1_ctl_reg.op == OP_UPD_B) ? rd_data[d+3] : rd_data[d];
        end
        case (p1_ctl_reg.comp)
            COMP_EX: p1_rdata = rd_data[0];
            COMP_EY: p1_rdata = rd_data[1];
            COMP_EZ: p1_rdata = rd_data[2];
            COMP_BX: p1_rdata = rd_data[3];
            COMP_BY: p1_rdata = rd_data[4];
            COMP_BZ: p1_rdata = rd_data[5];
            default: p1_rdata = '0;
        endcase
    end

    smpu_cross_unit #(.FB(FB), .TW(TW)) u_cross_x (
        .clk  (clk), .en (en), .ka (ky_reg), .kb (kz_reg),
        .p_re ($signed(src[2][DW-1:FB])), .p_im ($signed(src[2][FB-1:0])),
        .q_re ($signed(src[1][DW-1:FB])), .q_im ($signed(src[1][FB-1:0])),
        .t_re (t_re[0]), .t_im (t_im[0])
    );

    smpu_cross_unit #(.FB(FB), .TW(TW)) u_cross_y (
        .clk  (clk), .en (en), .ka (kx_reg), .kb (kz_reg),
        .p_re ($signed(src[2][DW-1:FB])), .p_im ($signed(src[2][FB-1:0])),
        .q_re ($signed(src[0][DW-1:FB])), .q_im ($signed(src[0][FB-1:0])),
        .t_re (t_re[1]), .t_im (t_im[1])
    );

    smpu_cross_unit #(.FB(FB), .TW(TW)) u_cross_z (
        .clk  (clk), .en (en), .ka (kx_reg), .kb (ky_reg),
        .p_re ($signed(src[1][DW-1:FB])), .p_im ($signed(src[1][FB-1:0])),
        .q_re ($signed(src[0][DW-1:FB])), .q_im ($signed(src[0][FB-1:0])),
        .t_re (t_re[0+2]), .t_im (t_im[0+2])
    );

    // add, clip, write back
    always_comb
    begin
        logic               pos;
        logic signed [UW-1:0] o_re, o_im, n_re, n_im;
        logic [FB:0]        c_re, c_im;
        for (int d = 0; d < 3; d++)
        begin
            pos  = (d != 1) ^ (p3_ctl_reg.op == OP_UPD_B);
            o_re = UW'($signed(p3_old_reg[d][DW-1:FB]));
            o_im = UW'($signed(p3_old_reg[d][FB-1:0]));
            n_re = pos ? o_re - UW'(t_im[d]) : o_re + UW'(t_im[d]);
            n_im = pos ? o_im + UW'(t_re[d]) : o_im - UW'(t_re[d]);
            c_re = clip_upd(n_re);
            c_im = clip_upd(n_im);
            upd[d]      = {c_re[FB-1:0], c_im[FB-1:0]};
            clip_hit[d] = c_re[FB] | c_im[FB];
        end
    end

    assign p3_upd = p3_ctl_reg.ok
                 && (p3_ctl_reg.op == OP_UPD_E || p3_ctl_reg.op == OP_UPD_B);

    always_comb
    begin
        for (int m = 0; m < 6; m++)
        begin
            case (p3_ctl_reg.op)
                OP_WRITE: we[m] = p3_ctl_reg.comp == 3'(m);
                OP_UPD_E: we[m] = m < 3;
                OP_UPD_B: we[m] = m >= 3;
                default:  we[m] = 1'b0;
            endcase
            we[m]    = we[m] && en && p3_valid_reg && p3_ctl_reg.ok;
            wdata[m] = (p3_ctl_reg.op == OP_WRITE) ? p3_ctl_reg.wval : upd[m % 3];
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (p3_ctl_reg.op == OP_READ && p3_ctl_reg.ok)
            begin
                data_re_reg <= 32'($signed(p3_rdata_reg[DW-1:FB]));
                data_im_reg <= 32'($signed(p3_rdata_reg[FB-1:0]));
            end
            else
            begin
                data_re_reg <= '0;
                data_im_reg <= '0;
            end
            sat_reg <= p3_upd && (|clip_hit);
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.data_re   = data_re_reg;
    assign out_ch.data_im   = data_im_reg;
    assign out_ch.saturated = sat_reg;

    `SMPU_ASSERT_NOW(a_no_accept_on_hazard, clk, rst_n, in_xfer, !hazard)
    `SMPU_ASSERT_NOW(a_write_from_p3, clk, rst_n, |we, p3_valid_reg && en)
    `SMPU_ASSERT_NOW(a_write_count, clk, rst_n, 1'b1, $countones(we) <= 3)
    `SMPU_ASSERT_NEXT(a_p3_to_out, clk, rst_n, en && p3_valid_reg, out_valid_reg)
endmodule
